// ===== hdl/msit_pkg.sv =====
// ----------------------------------------------------------------------------
// msit_pkg
// Shared widths, command kinds and result status codes of the interval timer.
// ----------------------------------------------------------------------------
package msit_pkg;

  localparam int TIME_W   = 32;
  localparam int KIND_W   = 2;
  localparam int ID_W     = 4;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 3;

  localparam logic [KIND_W-1:0] KIND_START   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK    = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_STARTED   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_FREE   = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_STOPPED   = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_RESTARTED = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_BAD_ID    = 3'd4;
  localparam logic [STATUS_W-1:0] STAT_EXPIRED   = 3'd5;
  localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd6;

  typedef logic [TIME_W-1:0] time_ms_t;

endpackage

// ===== hdl/msit_ram.sv =====
// ----------------------------------------------------------------------------
// msit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/msit_expiry.sv =====
// ----------------------------------------------------------------------------
// msit_expiry
// Shared subtract-and-compare unit: elapsed time against the slot period.
// ----------------------------------------------------------------------------
module msit_expiry
  import msit_pkg::*;
(
  input  time_ms_t now_ms,
  input  time_ms_t stamp_ms,
  input  time_ms_t interval,
  output logic     expired
);

  time_ms_t elapsed;

  // wrapping difference modulo 2^32
  assign elapsed = now_ms - stamp_ms;
  assign expired = (elapsed >= interval);

endmodule

// ===== hdl/multi_slot_interval_timer_unit.sv =====
// ----------------------------------------------------------------------------
// multi_slot_interval_timer_unit
// Table of SLOTS interval timers driven by commands carrying millisecond time.
// ----------------------------------------------------------------------------
// Start, stop and restart register the command in ST_IDLE and write their
// result to the output register from ST_START or ST_CMD. A tick scan visits
// each slot in turn: ST_RD reads its period, tick stamp and mode bits from the
// RAMs and ST_EVAL judges it in the single subtract-and-compare unit, then the
// done result follows. A result that cannot leave because the output register
// is still full holds the sequencer until it is taken. The input is not ready
// while a command is in progress. The slot table comes out of reset with every
// slot stopped; no clearing pass is needed.
module multi_slot_interval_timer_unit
  import msit_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [TIME_W-1:0]   in_now_ms,
  input  logic [TIME_W-1:0]   in_period,
  input  logic                in_repeat_mode,
  input  logic                in_notify_enable,
  input  logic [ID_W-1:0]     in_slot_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic                out_last
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CMD,
    ST_RD,
    ST_EVAL,
    ST_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [IW-1:0]       idx_r;
  logic [SLOTS-1:0]    running_r;

  logic [KIND_W-1:0]   kind_r;
  time_ms_t            now_r;
  time_ms_t            period_r;
  logic                rep_r;
  logic                ntf_r;
  logic [ID_W-1:0]     id_r;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic                out_last_r;

  logic                out_free;
  logic                found;
  logic [IW-1:0]       free_idx;
  logic                id_bad;
  logic [IW-1:0]       id_idx;
  time_ms_t            int_rd;
  time_ms_t            tick_rd;
  logic [1:0]          mode_rd;
  logic                expired;
  logic                hit;
  logic                need_out;
  logic                go;
  logic                idx_end;

  logic                emit;
  logic [STATUS_W-1:0] em_status;
  logic [SLOT_W-1:0]   em_slot;
  logic                em_last;
  logic                int_we;
  logic                tick_we;
  logic [IW-1:0]       wr_addr;
  logic                run_set;
  logic                run_clr;
  logic [IW-1:0]       run_addr;
  logic                mode_we;

  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;
  assign out_last   = out_last_r;

  assign out_free = !out_valid_r || out_ready;
  assign id_bad   = ({1'b0, id_r} >= 5'(SLOTS));
  assign id_idx   = id_r[IW-1:0];
  assign idx_end  = (idx_r == IW'(SLOTS - 1));

  // lowest slot not running
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!running_r[i]) begin
        found    = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  msit_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_int_ram (
    .clk   (clk),
    .we    (int_we),
    .waddr (wr_addr),
    .wdata (period_r),
    .raddr (idx_r),
    .rdata (int_rd)
  );

  msit_ram #(.WIDTH(TIME_W), .DEPTH(SLOTS)) u_tick_ram (
    .clk   (clk),
    .we    (tick_we),
    .waddr (wr_addr),
    .wdata (now_r),
    .raddr (idx_r),
    .rdata (tick_rd)
  );

  // slot mode bits: periodic above notify, written by start only
  msit_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_mode_ram (
    .clk   (clk),
    .we    (mode_we),
    .waddr (wr_addr),
    .wdata ({rep_r, ntf_r}),
    .raddr (idx_r),
    .rdata (mode_rd)
  );

  msit_expiry u_expiry (
    .now_ms   (now_r),
    .stamp_ms (tick_rd),
    .interval (int_rd),
    .expired  (expired)
  );

  assign hit      = running_r[idx_r] && expired;
  assign need_out = hit && mode_rd[0];
  assign go       = !need_out || out_free;

  always_comb begin
    state_nxt = state_r;
    emit      = 1'b0;
    em_status = STAT_DONE;
    em_slot   = '0;
    em_last   = 1'b1;
    int_we    = 1'b0;
    tick_we   = 1'b0;
    wr_addr   = idx_r;
    run_set   = 1'b0;
    run_clr   = 1'b0;
    run_addr  = idx_r;
    mode_we   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            KIND_START:   state_nxt = ST_START;
            KIND_STOP:    state_nxt = ST_CMD;
            KIND_RESTART: state_nxt = ST_CMD;
            KIND_TICK:    state_nxt = ST_RD;
            default:      state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_START: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          if (found) begin
            em_status = STAT_STARTED;
            em_slot   = SLOT_W'(free_idx);
            int_we    = 1'b1;
            tick_we   = 1'b1;
            wr_addr   = free_idx;
            run_set   = 1'b1;
            run_addr  = free_idx;
            mode_we   = 1'b1;
          end else begin
            em_status = STAT_NO_FREE;
          end
        end
      end
      ST_CMD: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          if (id_bad) begin
            em_status = STAT_BAD_ID;
          end else if (kind_r == KIND_STOP) begin
            em_status = STAT_STOPPED;
            em_slot   = SLOT_W'(id_idx);
            run_clr   = 1'b1;
            run_addr  = id_idx;
          end else begin
            em_status = STAT_RESTARTED;
            em_slot   = SLOT_W'(id_idx);
            tick_we   = 1'b1;
            wr_addr   = id_idx;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (go) begin
          if (hit) begin
            tick_we = 1'b1;
            run_clr = !mode_rd[1];
          end
          if (need_out) begin
            emit      = 1'b1;
            em_status = STAT_EXPIRED;
            em_slot   = SLOT_W'(idx_r);
            em_last   = 1'b0;
          end
          state_nxt = idx_end ? ST_DONE : ST_RD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      running_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && in_valid) begin
        idx_r    <= '0;
        kind_r   <= in_kind;
        now_r    <= in_now_ms;
        period_r <= in_period;
        rep_r    <= in_repeat_mode;
        ntf_r    <= in_notify_enable;
        id_r     <= in_slot_id;
      end else if (state_r == ST_EVAL && go && !idx_end) begin
        idx_r <= idx_r + 1'b1;
      end
      if (run_set) begin
        running_r[run_addr] <= 1'b1;
      end else if (run_clr) begin
        running_r[run_addr] <= 1'b0;
      end
      if (emit) begin
        out_valid_r  <= 1'b1;
        out_status_r <= em_status;
        out_slot_r   <= em_slot;
        out_last_r   <= em_last;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_running_quiet_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> $stable(running_r))
    else $error("slot table changed with no command in progress");

  a_emit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote an output register not yet taken");

  a_expired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STAT_EXPIRED) |-> !out_last_r)
    else $error("expiry result marked as final");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IW'(SLOTS - 1))
    else $error("scan index beyond slot table");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multi-slot interval timer unit. Commands are
// sent over the input channel while a behavioural timer table kept in the
// bench predicts every result; each result transfer is checked field by field
// against the oldest prediction. Directed commands cover the table edges,
// then random command streams run with random stalls on both channels,
// without stalls, and across the 32-bit millisecond wrap.
// ----------------------------------------------------------------------------
module testbench;
  import msit_pkg::*;

  localparam int SLOTS = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                is_last;
  } timer_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [KIND_W-1:0]   in_kind = KIND_START;
  time_ms_t            in_now_ms = '0;
  time_ms_t            in_period = '0;
  logic                in_repeat_mode = 1'b0;
  logic                in_notify_enable = 1'b0;
  logic [ID_W-1:0]     in_slot_id = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_last;

  // timer table as the bench sees it
  logic     slot_running  [SLOTS];
  logic     slot_periodic [SLOTS];
  logic     slot_notify   [SLOTS];
  time_ms_t slot_interval [SLOTS];
  time_ms_t slot_stamp    [SLOTS];

  timer_result_t expected_results[$];
  timer_result_t want;

  int       stall_pct = 28;
  time_ms_t sim_now = '0;
  int       n_commands = 0;
  int       n_directed = 0;
  int       n_checked = 0;
  int       n_expiries = 0;
  int       n_no_free = 0;
  int       n_errors = 0;
  int       quiet_cycles = 0;

  multi_slot_interval_timer_unit #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_now_ms        (in_now_ms),
    .in_period        (in_period),
    .in_repeat_mode   (in_repeat_mode),
    .in_notify_enable (in_notify_enable),
    .in_slot_id       (in_slot_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_slot         (out_slot),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      slot_running[i]  = 1'b0;
      slot_periodic[i] = 1'b0;
      slot_notify[i]   = 1'b0;
      slot_interval[i] = '0;
      slot_stamp[i]    = '0;
    end
  end

  task automatic predict_timer_table(input logic [KIND_W-1:0] kind, input time_ms_t now,
                                     input time_ms_t per, input logic rep,
                                     input logic ntf, input logic [ID_W-1:0] id);
    int       free_slot;
    time_ms_t elapsed;
    free_slot = -1;
    case (kind)
      KIND_START: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!slot_running[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          n_no_free++;
          expected_results.push_back({STAT_NO_FREE, 3'd0, 1'b1});
        end else begin
          slot_interval[free_slot] = per;
          slot_periodic[free_slot] = rep;
          slot_notify[free_slot]   = ntf;
          slot_stamp[free_slot]    = now;
          slot_running[free_slot]  = 1'b1;
          expected_results.push_back({STAT_STARTED, free_slot[SLOT_W-1:0], 1'b1});
        end
      end
      KIND_STOP, KIND_RESTART: begin
        if (id >= SLOTS) begin
          expected_results.push_back({STAT_BAD_ID, 3'd0, 1'b1});
        end else if (kind == KIND_STOP) begin
          slot_running[id] = 1'b0;
          expected_results.push_back({STAT_STOPPED, id[SLOT_W-1:0], 1'b1});
        end else begin
          slot_stamp[id] = now;
          expected_results.push_back({STAT_RESTARTED, id[SLOT_W-1:0], 1'b1});
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          elapsed = now - slot_stamp[i];
          if (slot_running[i] && elapsed >= slot_interval[i]) begin
            slot_stamp[i] = now;
            if (slot_notify[i]) begin
              n_expiries++;
              expected_results.push_back({STAT_EXPIRED, i[SLOT_W-1:0], 1'b0});
            end
            if (!slot_periodic[i]) slot_running[i] = 1'b0;
          end
        end
        expected_results.push_back({STAT_DONE, 3'd0, 1'b1});
      end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_command(input logic [KIND_W-1:0] kind, input time_ms_t now,
                              input time_ms_t per, input logic rep, input logic ntf,
                              input logic [ID_W-1:0] id);
    while ($urandom_range(0, 99) < stall_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_kind          = kind;
    in_now_ms        = now;
    in_period        = per;
    in_repeat_mode   = rep;
    in_notify_enable = ntf;
    in_slot_id       = id;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_timer_table(kind, now, per, rep, ntf, id);
    n_commands++;
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_random(input int unsigned step_max);
    logic [KIND_W-1:0] kind;
    int unsigned       pick;
    time_ms_t          per;
    logic [ID_W-1:0]   id;
    logic              rep;
    logic              ntf;
    pick = $urandom_range(0, 99);
    if (pick < 30) kind = KIND_START;
    else if (pick < 50) kind = KIND_STOP;
    else if (pick < 62) kind = KIND_RESTART;
    else kind = KIND_TICK;
    if ($urandom_range(0, 49) == 0) sim_now = $urandom();
    else sim_now = sim_now + $urandom_range(0, step_max);
    if ($urandom_range(0, 9) == 0) per = $urandom();
    else per = $urandom_range(0, 40);
    if ($urandom_range(0, 3) == 0) id = ID_W'($urandom_range(SLOTS, 15));
    else id = ID_W'($urandom_range(0, SLOTS - 1));
    rep = 1'($urandom_range(0, 1));
    ntf = 1'($urandom_range(0, 1));
    send_command(kind, sim_now, per, rep, ntf, id);
  endtask

  task automatic test_basic_commands();
    // empty table, then fill every slot with mixed modes
    send_command(KIND_TICK,  32'd0,          32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15);
    send_command(KIND_START, 32'd0,          32'd0,         1'b1, 1'b1, 4'd0);
    send_command(KIND_START, 32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b0, 1'b1, 4'd15);
    send_command(KIND_START, 32'd100,        32'd5,         1'b0, 1'b0, 4'd0);
    send_command(KIND_START, 32'd100,        32'd10,        1'b1, 1'b1, 4'd0);
    send_command(KIND_START, 32'd100,        32'd3,         1'b0, 1'b1, 4'd0);
    send_command(KIND_START, 32'd100,        32'd7,         1'b1, 1'b0, 4'd0);
    send_command(KIND_START, 32'd100,        32'd1,         1'b1, 1'b1, 4'd0);
    send_command(KIND_START, 32'd100,        32'd20,        1'b0, 1'b1, 4'd0);
    // table full
    send_command(KIND_START, 32'd101,        32'd9,         1'b1, 1'b1, 4'd0);
    send_command(KIND_TICK,  32'd105,        32'd0,         1'b0, 1'b0, 4'd0);
    // out of range ids
    send_command(KIND_STOP,    32'd106,      32'hFFFF_FFFF, 1'b1, 1'b1, 4'd15);
    send_command(KIND_RESTART, 32'd106,      32'd0,         1'b1, 1'b1, 4'd8);
    // idle slot after a silent one-shot expiry
    send_command(KIND_STOP,    32'd107,      32'd0,         1'b0, 1'b0, 4'd2);
    send_command(KIND_RESTART, 32'd107,      32'd0,         1'b0, 1'b0, 4'd2);
    send_command(KIND_RESTART, 32'd200,      32'd0,         1'b0, 1'b0, 4'd3);
    send_command(KIND_TICK,    32'd210,      32'd0,         1'b0, 1'b0, 4'd0);
    send_command(KIND_TICK,    32'hFFFF_FFFE, 32'd0,        1'b0, 1'b0, 4'd0);
    send_command(KIND_STOP,    32'hFFFF_FFFE, 32'd0,        1'b0, 1'b0, 4'd7);
    send_command(KIND_STOP,    32'hFFFF_FFFE, 32'd0,        1'b0, 1'b0, 4'd0);
    send_command(KIND_START,   32'hFFFF_FFFF, 32'd2,        1'b1, 1'b1, 4'd0);
    send_command(KIND_TICK,    32'd1,         32'd0,        1'b0, 1'b0, 4'd0);
    n_directed = n_commands;
    sim_now = 32'd1;
    wait_results_drained();
  endtask

  task automatic test_random_mix();
    stall_pct = 28;
    repeat (290) send_random(12);
    wait_results_drained();
  endtask

  task automatic test_back_to_back();
    stall_pct = 0;
    repeat (80) send_random(6);
    wait_results_drained();
  endtask

  task automatic test_time_wrap();
    stall_pct = 28;
    sim_now = 32'hFFFF_FF80;
    repeat (70) send_random(8);
    wait_results_drained();
  endtask

  always @(negedge clk) begin
    out_ready = ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0d slot %0d last %0d",
                 $time, out_status, out_slot, out_last);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
          n_errors++;
        end
        if (out_slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, out_slot);
          n_errors++;
        end
        if (out_last !== want.is_last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.is_last, out_last);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_basic_commands();
    test_random_mix();
    test_back_to_back();
    test_time_wrap();
    in_valid = 1'b0;
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    $display("covered %0d commands (%0d directed), %0d results checked", n_commands,
             n_directed, n_checked);
    $display("%0d notified expiries and %0d full-table starts, with and without stalls",
             n_expiries, n_no_free);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
